// File: hdl/tun_pkg.sv
`default_nettype none
package tun_pkg;

  // Field and datapath widths.
  localparam int COORD_W   = 24;
  localparam int EDGE_W    = COORD_W + 1;
  localparam int PROD_W    = 2 * EDGE_W;
  localparam int CROSS_W   = PROD_W + 1;
  localparam int MAG_W     = PROD_W;
  localparam int BLEN_W    = 6;
  localparam int M_W       = 31;
  localparam int SUM_W     = 64;
  localparam int ROOT_W    = 32;
  localparam int REM_W     = ROOT_W + 3;
  localparam int FRAC_W    = 14;
  localparam int Q_W       = FRAC_W + 1;
  localparam int NUM_W     = M_W + FRAC_W + 1;
  localparam int OUT_W     = 16;
  localparam int MINLEN_W  = 16;
  localparam int SMALL_W   = 16;

  // Square root pipeline: one result bit per step.
  localparam int SQ_STEPS  = 4;
  localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

  // Divider pipeline: one quotient bit per step.
  localparam int DV_STEPS  = 3;
  localparam int DV_STAGES = Q_W / DV_STEPS;

  localparam logic [Q_W-1:0] ONE_Q = Q_W'(1) << FRAC_W;

  // Sign and fallback flag carried alongside the datapath.
  typedef struct packed {
    logic [2:0] sgn;
    logic       deg;
  } tun_side_t;

  // Square root recurrence state.
  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
    logic [SUM_W-1:0]  x;
  } tun_sq_t;

  // Divider recurrence state for one lane.
  typedef struct packed {
    logic [ROOT_W-1:0] rem;
    logic [Q_W-1:0]    feed;
    logic [Q_W-1:0]    q;
  } tun_dv_t;

endpackage
`default_nettype wire

// File: hdl/triangle_unit_normal.sv
`default_nettype none
// Channel   Direction  Words                          Notes
// s_axis    in         one triangle, 216-bit tdata    ax..cz, 24 bits each
// m_axis    out        one unit normal, 48-bit tdata  tuser = degenerate
// cfg       in         min_length, 16 bits            single register
//
// One triangle enters per cycle unless a stall at m_axis has filled the pipeline; each
// result is offered on m_axis after its triangle passes 23 register stages in a row.
// The stage count is set by the square root (32 result bits, four per stage)
// and the quotient pipeline (15 bits, three per stage) on top of the
// cross product and scaling stages.
// Reset is synchronous and clears only the valid bits and min_length.
// A stall at m_axis moves back stage by stage; empty stages keep filling.
module triangle_unit_normal
  import tun_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz from bit 0 up, 24 bits each
  input  wire logic [9*COORD_W-1:0]   s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // nx, ny, nz from bit 0 up, 16 bits each
  output logic [3*OUT_W-1:0]          m_axis_tdata,
  // degenerate
  output logic                        m_axis_tuser,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [MINLEN_W-1:0]    cfg_data
);

  logic [MINLEN_W-1:0]       min_length;
  logic [8:0][COORD_W-1:0]   corners;

  logic                      x_valid, x_ready;
  logic [2:0][MAG_W-1:0]     x_mag;
  logic [2:0]                x_sgn;

  logic                      s_valid, s_ready;
  logic [SUM_W-1:0]          s_sum;
  logic [2:0][M_W-1:0]       s_m;
  tun_side_t                 s_side;

  logic                      r_valid, r_ready;
  logic [ROOT_W-1:0]         r_len;
  logic [2:0][M_W-1:0]       r_m;
  tun_side_t                 r_side;

  logic                      d_valid, d_ready;
  logic [2:0][Q_W-1:0]       d_q;
  tun_side_t                 d_side;

  logic                      o_valid;
  logic [2:0][OUT_W-1:0]     o_n;
  logic                      o_deg;
  logic [2:0][Q_W-1:0]       qc;

  // Threshold register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_length <= '0;
    end else if (cfg_valid) begin
      min_length <= cfg_data;
    end
  end

  assign corners = s_axis_tdata;

  tun_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .corners   (corners),
    .out_valid (x_valid),
    .out_ready (x_ready),
    .mag       (x_mag),
    .sgn       (x_sgn)
  );

  tun_scale u_scale (
    .clk        (clk),
    .rst        (rst),
    .min_length (min_length),
    .in_valid   (x_valid),
    .in_ready   (x_ready),
    .mag        (x_mag),
    .sgn        (x_sgn),
    .out_valid  (s_valid),
    .out_ready  (s_ready),
    .sum        (s_sum),
    .m          (s_m),
    .side       (s_side)
  );

  tun_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .sum       (s_sum),
    .m_in      (s_m),
    .side_in   (s_side),
    .out_valid (r_valid),
    .out_ready (r_ready),
    .len       (r_len),
    .m_out     (r_m),
    .side_out  (r_side)
  );

  tun_div u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (r_valid),
    .in_ready  (r_ready),
    .len       (r_len),
    .m         (r_m),
    .side_in   (r_side),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .q         (d_q),
    .side_out  (d_side)
  );

  // Quotients clamped to one.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      qc[i] = (d_q[i] > ONE_Q) ? ONE_Q : d_q[i];
    end
  end

  // Output register: apply sign, or give the fallback normal.
  assign d_ready = ~o_valid | m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (d_ready) begin
      o_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready) begin
      o_deg <= d_side.deg;
      for (int i = 0; i < 3; i++) begin
        if (d_side.deg) begin
          o_n[i] <= (i == 1) ? OUT_W'(ONE_Q) : '0;
        end else if (d_side.sgn[i]) begin
          o_n[i] <= OUT_W'(-{1'b0, qc[i]});
        end else begin
          o_n[i] <= OUT_W'(qc[i]);
        end
      end
    end
  end

  assign m_axis_tvalid = o_valid;
  assign m_axis_tdata  = o_n;
  assign m_axis_tuser  = o_deg;

endmodule
`default_nettype wire

// File: hdl/tun_cross.sv
`default_nettype none
module tun_cross
  import tun_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [8:0][COORD_W-1:0]       corners,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0][MAG_W-1:0]              mag,
  output logic [2:0]                         sgn
);

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  logic signed [EDGE_W-1:0]  ux, uy, uz, vx, vy, vz;
  logic signed [PROD_W-1:0]  p0, p1, p2, p3, p4, p5;
  logic signed [CROSS_W-1:0] n0, n1, n2;
  logic [2:0][MAG_W-1:0]     mag_r;
  logic [2:0]                sgn_r;

  // Stage enables: a stage moves when it is empty or the next one moves.
  always_comb begin
    en[NST-1] = ~vld[NST-1] | out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Edge vectors from the first corner.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      ux <= $signed({corners[3][COORD_W-1], corners[3]}) -
            $signed({corners[0][COORD_W-1], corners[0]});
      uy <= $signed({corners[4][COORD_W-1], corners[4]}) -
            $signed({corners[1][COORD_W-1], corners[1]});
      uz <= $signed({corners[5][COORD_W-1], corners[5]}) -
            $signed({corners[2][COORD_W-1], corners[2]});
      vx <= $signed({corners[6][COORD_W-1], corners[6]}) -
            $signed({corners[0][COORD_W-1], corners[0]});
      vy <= $signed({corners[7][COORD_W-1], corners[7]}) -
            $signed({corners[1][COORD_W-1], corners[1]});
      vz <= $signed({corners[8][COORD_W-1], corners[8]}) -
            $signed({corners[2][COORD_W-1], corners[2]});
    end
  end

  // The six partial products of the cross product.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      p0 <= uy * vz;
      p1 <= uz * vy;
      p2 <= uz * vx;
      p3 <= ux * vz;
      p4 <= ux * vy;
      p5 <= uy * vx;
    end
  end

  // Cross product components, exact.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      n0 <= $signed({p0[PROD_W-1], p0}) - $signed({p1[PROD_W-1], p1});
      n1 <= $signed({p2[PROD_W-1], p2}) - $signed({p3[PROD_W-1], p3});
      n2 <= $signed({p4[PROD_W-1], p4}) - $signed({p5[PROD_W-1], p5});
    end
  end

  // Split into sign and magnitude.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sgn_r    <= {n2[CROSS_W-1], n1[CROSS_W-1], n0[CROSS_W-1]};
      mag_r[0] <= n0[CROSS_W-1] ? MAG_W'(-n0) : n0[MAG_W-1:0];
      mag_r[1] <= n1[CROSS_W-1] ? MAG_W'(-n1) : n1[MAG_W-1:0];
      mag_r[2] <= n2[CROSS_W-1] ? MAG_W'(-n2) : n2[MAG_W-1:0];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];
  assign mag       = mag_r;
  assign sgn       = sgn_r;

endmodule
`default_nettype wire

// File: hdl/tun_scale.sv
`default_nettype none
module tun_scale
  import tun_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [MINLEN_W-1:0]        min_length,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0][MAG_W-1:0]      mag,
  input  wire logic [2:0]                 sgn,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [SUM_W-1:0]                sum,
  output logic [2:0][M_W-1:0]             m,
  output tun_side_t                       side
);

  localparam int NST = 4;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  logic [2:0][MAG_W-1:0]     mag0;
  logic [2:0]                sgn0, sgn1, sgn2;
  logic [BLEN_W-1:0]         blen0;
  logic                      small0, small1;
  logic [2:0][M_W-1:0]       m1, m2, m3;
  logic [2:0][2*SMALL_W-1:0] sq1;
  logic [2*MINLEN_W-1:0]     lim1;
  logic [2:0][2*M_W-1:0]     msq2;
  logic                      deg2;
  logic [SUM_W-1:0]          sum3;
  tun_side_t                 side3;

  logic [MAG_W-1:0]          orv;
  logic [BLEN_W-1:0]         blen_c;
  logic [2*SMALL_W+1:0]      dsum;

  always_comb begin
    en[NST-1] = ~vld[NST-1] | out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Bit length of the largest magnitude: highest set bit of their OR.
  always_comb begin
    orv    = mag[0] | mag[1] | mag[2];
    blen_c = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (orv[i]) blen_c = BLEN_W'(i + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      mag0   <= mag;
      sgn0   <= sgn;
      blen0  <= blen_c;
      small0 <= (orv[MAG_W-1:SMALL_W] == '0);
    end
  end

  // Common shift so the largest magnitude has exactly M_W bits; exact
  // squares of short vectors for the degenerate test.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < 3; i++) begin
        if (blen0 > BLEN_W'(M_W)) begin
          m1[i] <= M_W'(mag0[i] >> (blen0 - BLEN_W'(M_W)));
        end else begin
          m1[i] <= M_W'(mag0[i] << (BLEN_W'(M_W) - blen0));
        end
        sq1[i] <= mag0[i][SMALL_W-1:0] * mag0[i][SMALL_W-1:0];
      end
      lim1   <= min_length * min_length;
      small1 <= small0;
      sgn1   <= sgn0;
    end
  end

  assign dsum = (2*SMALL_W+2)'(sq1[0]) + (2*SMALL_W+2)'(sq1[1]) +
                (2*SMALL_W+2)'(sq1[2]);

  // Squares of the scaled components; fallback decision.
  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int i = 0; i < 3; i++) begin
        msq2[i] <= m1[i] * m1[i];
      end
      deg2 <= small1 && (dsum <= (2*SMALL_W+2)'(lim1));
      m2   <= m1;
      sgn2 <= sgn1;
    end
  end

  // Sum of squares.
  always_ff @(posedge clk) begin
    if (en[3]) begin
      sum3       <= SUM_W'(msq2[0]) + SUM_W'(msq2[1]) + SUM_W'(msq2[2]);
      m3         <= m2;
      side3.sgn  <= sgn2;
      side3.deg  <= deg2;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];
  assign sum       = sum3;
  assign m         = m3;
  assign side      = side3;

endmodule
`default_nettype wire

// File: hdl/tun_sqrt.sv
`default_nettype none
module tun_sqrt
  import tun_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SUM_W-1:0]      sum,
  input  wire logic [2:0][M_W-1:0]   m_in,
  input  wire tun_side_t             side_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [ROOT_W-1:0]          len,
  output logic [2:0][M_W-1:0]        m_out,
  output tun_side_t                  side_out
);

  localparam int NST = SQ_STAGES;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  tun_sq_t                   st   [NST];
  logic [2:0][M_W-1:0]       mr   [NST];
  tun_side_t                 sr   [NST];
  tun_sq_t                   init;

  // Several steps of the digit-by-digit square root, two bits per step.
  function automatic tun_sq_t sq_steps(input tun_sq_t a);
    tun_sq_t          r;
    logic [REM_W-1:0] t;
    logic [REM_W-1:0] trial;
    r = a;
    for (int j = 0; j < SQ_STEPS; j++) begin
      t     = {r.rem[REM_W-3:0], r.x[SUM_W-1:SUM_W-2]};
      r.x   = r.x << 2;
      trial = {1'b0, r.root, 2'b01};
      if (t >= trial) begin
        r.rem  = t - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = t;
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  always_comb begin
    en[NST-1] = ~vld[NST-1] | out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  always_comb begin
    init.rem  = '0;
    init.root = '0;
    init.x    = sum;
  end

  // Root stages with the operands riding along.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      st[0] <= sq_steps(init);
      mr[0] <= m_in;
      sr[0] <= side_in;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        st[k] <= sq_steps(st[k-1]);
        mr[k] <= mr[k-1];
        sr[k] <= sr[k-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];
  assign len       = st[NST-1].root;
  assign m_out     = mr[NST-1];
  assign side_out  = sr[NST-1];

endmodule
`default_nettype wire

// File: hdl/tun_div.sv
`default_nettype none
module tun_div
  import tun_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [ROOT_W-1:0]     len,
  input  wire logic [2:0][M_W-1:0]   m,
  input  wire tun_side_t             side_in,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [2:0][Q_W-1:0]        q,
  output tun_side_t                  side_out
);

  localparam int NST = DV_STAGES + 1;

  logic [NST-1:0] vld;
  logic [NST-1:0] en;

  tun_dv_t                   st  [NST][3];
  logic [ROOT_W-1:0]         lr  [NST];
  tun_side_t                 sr  [NST];
  logic [2:0][NUM_W-1:0]     num;

  // Restoring division, one quotient bit per step.
  function automatic tun_dv_t dv_steps(input tun_dv_t a, input logic [ROOT_W-1:0] d);
    tun_dv_t           r;
    logic [ROOT_W:0]   t;
    r = a;
    for (int j = 0; j < DV_STEPS; j++) begin
      t      = {r.rem, r.feed[Q_W-1]};
      r.feed = r.feed << 1;
      if (t >= {1'b0, d}) begin
        t   = t - {1'b0, d};
        r.q = {r.q[Q_W-2:0], 1'b1};
      end else begin
        r.q = {r.q[Q_W-2:0], 1'b0};
      end
      r.rem = t[ROOT_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    en[NST-1] = ~vld[NST-1] | out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = ~vld[k] | en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // Dividend with the rounding half of the divisor added in.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, m[i], {FRAC_W{1'b0}}} + NUM_W'(len[ROOT_W-1:1]);
    end
  end

  // The top bits of the dividend are already below the divisor, since the
  // quotient is known to fit in Q_W bits.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int i = 0; i < 3; i++) begin
        st[0][i].rem  <= ROOT_W'(num[i][NUM_W-1:Q_W]);
        st[0][i].feed <= num[i][Q_W-1:0];
        st[0][i].q    <= '0;
      end
      lr[0] <= len;
      sr[0] <= side_in;
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) begin
        for (int i = 0; i < 3; i++) begin
          st[k][i] <= dv_steps(st[k-1][i], lr[k-1]);
        end
        lr[k] <= lr[k-1];
        sr[k] <= sr[k-1];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i] = st[NST-1][i].q;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[NST-1];
  assign side_out  = sr[NST-1];

endmodule
`default_nettype wire

// File: tb/sv/tb_triangle_unit_normal.sv
`default_nettype none
module tb_triangle_unit_normal;
  timeunit 1ns;
  timeprecision 1ps;
  import tun_pkg::*;

  localparam int LATENCY = 23;
  localparam int WATCHDOG = 20000;

  typedef struct {
    logic signed [OUT_W-1:0] nx, ny, nz;
    logic deg;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [9*COORD_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [3*OUT_W-1:0] m_axis_tdata;
  logic m_axis_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [MINLEN_W-1:0] cfg_data = '0;

  triangle_unit_normal dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  logic [9*COORD_W-1:0] pending_tris[$];
  normal_t expected_normals[$];
  logic [MINLEN_W-1:0] min_length = '0;
  int send_idle_pct = 19;
  int recv_idle_pct = 47;
  int hold_cycles = 0;
  int errors = 0;
  int quiet_cycles = 0;

  // Face normal of one triangle, at the block's fixed-point formats.
  function automatic normal_t face_normal(input logic [9*COORD_W-1:0] tri_w,
                                          input logic [MINLEN_W-1:0] thresh);
    logic signed [COORD_W-1:0] c[9];
    logic signed [63:0] u[3], v[3];
    logic signed [127:0] n[3];
    logic [127:0] mag[3];
    logic [63:0] m[3], sum, x, r, bt, q, len;
    logic sgn[3];
    int blen, k;
    normal_t res;
    for (int i = 0; i < 9; i++) c[i] = tri_w[i*COORD_W +: COORD_W];
    for (int i = 0; i < 3; i++) begin
      u[i] = 64'(c[3+i]) - 64'(c[i]);
      v[i] = 64'(c[6+i]) - 64'(c[i]);
    end
    n[0] = 128'(u[1]) * 128'(v[2]) - 128'(u[2]) * 128'(v[1]);
    n[1] = 128'(u[2]) * 128'(v[0]) - 128'(u[0]) * 128'(v[2]);
    n[2] = 128'(u[0]) * 128'(v[1]) - 128'(u[1]) * 128'(v[0]);
    blen = 0;
    for (int i = 0; i < 3; i++) begin
      sgn[i] = n[i][127];
      mag[i] = sgn[i] ? -n[i] : n[i];
      for (k = 127; k >= 0; k--) if (mag[i][k]) break;
      if (k + 1 > blen) blen = k + 1;
    end
    res.deg = 1'b0;
    if (blen <= 31) begin
      sum = mag[0][63:0]*mag[0][63:0] + mag[1][63:0]*mag[1][63:0]
          + mag[2][63:0]*mag[2][63:0];
      if (sum <= 64'(thresh) * 64'(thresh)) begin
        res.nx = '0;
        res.ny = OUT_W'(1 << FRAC_W);
        res.nz = '0;
        res.deg = 1'b1;
        return res;
      end
    end
    for (int i = 0; i < 3; i++)
      m[i] = (blen > 31) ? 64'(mag[i] >> (blen - 31)) : (mag[i][63:0] << (31 - blen));
    sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
    // Integer square root, two bits per step.
    x = sum; r = 0; bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    len = (r == 0) ? 64'd1 : r;
    for (int i = 0; i < 3; i++) begin
      q = ((m[i] << FRAC_W) + (len >> 1)) / len;
      if (q > (64'd1 << FRAC_W)) q = 64'd1 << FRAC_W;
      if (sgn[i]) q = -q;
      if (i == 0) res.nx = q[OUT_W-1:0];
      else if (i == 1) res.ny = q[OUT_W-1:0];
      else res.nz = q[OUT_W-1:0];
    end
    return res;
  endfunction

  function automatic logic [COORD_W-1:0] rand_coord(input int mode);
    case (mode)
      0: return COORD_W'($urandom);
      1: return COORD_W'($signed($urandom_range(0, 64)) - 32);
      2: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
      default: return COORD_W'($signed($urandom_range(0, 8192)) - 4096);
    endcase
  endfunction

  function automatic logic [9*COORD_W-1:0] rand_tri();
    logic [9*COORD_W-1:0] t;
    int mode;
    mode = $urandom_range(0, 3);
    for (int i = 0; i < 9; i++) t[i*COORD_W +: COORD_W] = rand_coord(mode);
    // Some triangles are collinear or repeat a corner.
    if ($urandom_range(0, 9) == 0) t[3*COORD_W +: 3*COORD_W] = t[0 +: 3*COORD_W];
    else if ($urandom_range(0, 9) == 0)
      for (int i = 0; i < 3; i++)
        t[(6+i)*COORD_W +: COORD_W] = COORD_W'(t[(3+i)*COORD_W +: COORD_W] * 2
                                               - t[i*COORD_W +: COORD_W]);
    return t;
  endfunction

  function automatic logic [9*COORD_W-1:0] make_tri(input int ax, ay, az, bx, by, bz,
                                                    cx, cy, cz);
    return {COORD_W'(cz), COORD_W'(cy), COORD_W'(cx), COORD_W'(bz), COORD_W'(by),
            COORD_W'(bx), COORD_W'(az), COORD_W'(ay), COORD_W'(ax)};
  endfunction

  // Triangle driver.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (pending_tris.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        s_axis_tdata <= pending_tris[0];
        s_axis_tvalid <= 1'b1;
        expected_normals.insert(expected_normals.size(),
                                face_normal(pending_tris.pop_front(), min_length));
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready, with an optional long hold-off.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    normal_t exp_n;
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_normals.size() == 0) begin
          $error("unexpected normal word");
          errors++;
        end else begin
          exp_n = expected_normals.pop_front();
          if (m_axis_tdata[0 +: OUT_W] !== exp_n.nx) begin
            $error("nx expected %0d actual %0d", exp_n.nx, $signed(m_axis_tdata[0 +: OUT_W]));
            errors++;
          end
          if (m_axis_tdata[OUT_W +: OUT_W] !== exp_n.ny) begin
            $error("ny expected %0d actual %0d", exp_n.ny,
                   $signed(m_axis_tdata[OUT_W +: OUT_W]));
            errors++;
          end
          if (m_axis_tdata[2*OUT_W +: OUT_W] !== exp_n.nz) begin
            $error("nz expected %0d actual %0d", exp_n.nz,
                   $signed(m_axis_tdata[2*OUT_W +: OUT_W]));
            errors++;
          end
          if (m_axis_tuser !== exp_n.deg) begin
            $error("degenerate expected %0d actual %0d", exp_n.deg, m_axis_tuser);
            errors++;
          end
        end
      end
    end
  end

  task automatic drain();
    while (pending_tris.size() != 0 || expected_normals.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  task automatic write_min_length(input logic [MINLEN_W-1:0] val);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    min_length = val;
  endtask

  task automatic queue_tri(input logic [9*COORD_W-1:0] t);
    pending_tris.insert(pending_tris.size(), t);
  endtask

  task automatic queue_random(input int count);
    for (int i = 0; i < count; i++) queue_tri(rand_tri());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: extremes, flat and tiny triangles at the reset threshold.
    queue_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));
    queue_tri(make_tri(0, 0, 0, 0, 1, 0, 1, 0, 0));
    queue_tri(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0));
    queue_tri(make_tri(1, 2, 3, 2, 4, 6, 3, 6, 9));
    queue_tri(make_tri(-8388608, -8388608, -8388608, 8388607, -8388608,
                       -8388608, -8388608, 8388607, -8388608));
    queue_tri(make_tri(8388607, 8388607, 8388607, -8388608, 8388607,
                       -8388608, 8388607, -8388608, -8388608));
    queue_tri(make_tri(-8388608, 8388607, 0, 8388607, -8388608, 8388607,
                       0, 0, -8388608));
    queue_tri(make_tri(0, 0, 0, 4096, 4096, 0, -4096, 4096, 4096));
    queue_tri(make_tri(5, -3, 7, 6, -3, 7, 5, -2, 8));
    queue_tri(make_tri(-1, -1, -1, -1, -1, -1, 0, 0, 0));
    queue_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 7, 0));
    drain();
    write_min_length(16'd20);
    queue_tri(make_tri(0, 0, 0, 4, 0, 0, 0, 5, 0));
    queue_tri(make_tri(0, 0, 0, 3, 0, 0, 0, 7, 0));
    queue_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 21, 0));
    queue_tri(make_tri(0, 0, 0, 65535, 0, 0, 0, 1, 0));
    drain();
    write_min_length(16'hFFFF);
    queue_tri(make_tri(0, 0, 0, 65535, 0, 0, 0, 1, 0));
    queue_tri(make_tri(0, 0, 0, 65536, 0, 0, 0, 1, 0));
    queue_tri(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));
    drain();

    // Random phases with different idling and thresholds.
    send_idle_pct = 19; recv_idle_pct = 47;
    write_min_length(16'($urandom_range(0, 300)));
    queue_random(500);
    drain();
    send_idle_pct = 47; recv_idle_pct = 19;
    write_min_length(16'hFFFF);
    queue_random(250);
    drain();
    write_min_length(16'd0);
    queue_random(250);
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    write_min_length(16'($urandom));
    queue_random(500);
    // Long receiver hold-off while triangles keep arriving.
    repeat (20) @(posedge clk);
    hold_cycles = 200;
    drain();

    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: filelist.f
hdl/tun_pkg.sv
hdl/tun_cross.sv
hdl/tun_scale.sv
hdl/tun_sqrt.sv
hdl/tun_div.sv
hdl/triangle_unit_normal.sv
tb/sv/tb_triangle_unit_normal.sv
